### hw/rtl/mss_pkg.sv
`default_nettype none

package mss_pkg;

  localparam int unsigned CharW = 8;
  localparam int unsigned WinDepth = 4;

  localparam logic [CharW-1:0] ChrReset   = 8'h61; // 'a'
  localparam logic [CharW-1:0] ChrLBrace  = 8'h7b; // '{'
  localparam logic [CharW-1:0] ChrRBrace  = 8'h7d; // '}'
  localparam logic [CharW-1:0] ChrLt      = 8'h3c; // '<'
  localparam logic [CharW-1:0] ChrGt      = 8'h3e; // '>'
  localparam logic [CharW-1:0] ChrSlash   = 8'h2f; // '/'
  localparam logic [CharW-1:0] ChrBang    = 8'h21; // '!'
  localparam logic [CharW-1:0] ChrDash    = 8'h2d; // '-'
  localparam logic [CharW-1:0] ChrR       = 8'h72;
  localparam logic [CharW-1:0] ChrE       = 8'h65;
  localparam logic [CharW-1:0] ChrF       = 8'h66;
  localparam logic [CharW-1:0] ChrQ       = 8'h71;
  localparam logic [CharW-1:0] ChrU       = 8'h75;
  localparam logic [CharW-1:0] ChrO       = 8'h6f;
  localparam logic [CharW-1:0] ChrT       = 8'h74;

  // one character handed from the input register to the filter
  typedef struct packed {
    logic             valid;
    logic [CharW-1:0] chr;
  } mss_step_t;

endpackage

`default_nettype wire

### hw/rtl/mss_filter.sv
`default_nettype none

module mss_filter import mss_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  mss_step_t step_i,
  output logic      emit_o
);

  typedef enum logic [2:0] {
    ModeCopy    = 3'd0,
    ModeBrace   = 3'd1,
    ModeRef     = 3'd2,
    ModeQuote   = 3'd3,
    ModeComment = 3'd4
  } mode_e;

  mode_e            mode_q, mode_d;
  logic [CharW-1:0] win_q [WinDepth];
  logic [CharW-1:0] win_d [WinDepth];

  logic open_brace, open_ref, open_quot, open_cmt;
  logic close_brace, close_ref, close_cmt;
  logic emit;

  // window after the new character is shifted in, index 0 oldest
  always_comb begin
    for (int i = 0; i < WinDepth - 1; i++) begin
      win_d[i] = win_q[i+1];
    end
    win_d[WinDepth-1] = step_i.chr;
  end

  assign open_brace  = (win_d[2] == ChrLBrace) && (win_d[3] == ChrLBrace);
  assign open_ref    = (win_d[0] == ChrLt) && (win_d[1] == ChrR) &&
                       (win_d[2] == ChrE) && (win_d[3] == ChrF);
  assign open_quot   = (win_d[0] == ChrQ) && (win_d[1] == ChrU) &&
                       (win_d[2] == ChrO) && (win_d[3] == ChrT);
  assign open_cmt    = (win_d[0] == ChrLt) && (win_d[1] == ChrBang) &&
                       (win_d[2] == ChrDash) && (win_d[3] == ChrDash);
  assign close_brace = (win_d[2] == ChrRBrace) && (win_d[3] == ChrRBrace);
  assign close_ref   = (win_d[0] == ChrSlash) && (win_d[1] == ChrR) &&
                       (win_d[2] == ChrE) && (win_d[3] == ChrF);
  assign close_cmt   = (win_d[1] == ChrDash) && (win_d[2] == ChrDash) &&
                       (win_d[3] == ChrGt);

  always_comb begin
    mode_d = mode_q;
    emit   = 1'b0;
    case (mode_q)
      ModeBrace: begin
        if (close_brace) begin
          mode_d = ModeCopy;
          emit   = 1'b1;
        end
      end
      ModeRef: begin
        if (close_ref) begin
          mode_d = ModeCopy;
          emit   = 1'b1;
        end
      end
      ModeQuote: begin
        if (open_quot) begin
          mode_d = ModeCopy;
          emit   = 1'b1;
        end
      end
      ModeComment: begin
        if (close_cmt) begin
          mode_d = ModeCopy;
          emit   = 1'b1;
        end
      end
      default: begin
        // priority follows the order the openings are tested
        if (open_brace) begin
          mode_d = ModeBrace;
        end else if (open_ref) begin
          mode_d = ModeRef;
        end else if (open_quot) begin
          mode_d = ModeQuote;
        end else if (open_cmt) begin
          mode_d = ModeComment;
        end else begin
          mode_d = ModeCopy;
          emit   = 1'b1;
        end
      end
    endcase
  end

  assign emit_o = step_i.valid & emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeCopy;
      for (int i = 0; i < WinDepth; i++) begin
        win_q[i] <= ChrReset;
      end
    end else if (step_i.valid) begin
      mode_q <= mode_d;
      for (int i = 0; i < WinDepth; i++) begin
        win_q[i] <= win_d[i];
      end
    end
  end

`ifndef SYNTHESIS
  a_close_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i.valid && mode_q != ModeCopy && mode_d == ModeCopy |-> emit_o)
    else $error("closing character not emitted");

  a_open_drops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i.valid && mode_q == ModeCopy && mode_d != ModeCopy |-> !emit_o)
    else $error("opening character emitted");

  a_skip_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i.valid && mode_q != ModeCopy && mode_d != ModeCopy |->
      mode_d == mode_q && !emit_o)
    else $error("skip mode changed without close");

  a_idle_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i.valid |=> $stable(mode_q))
    else $error("mode moved without a character");
`endif

endmodule

`default_nettype wire

### hw/rtl/markup_span_stripper_unit.sv
// accepted characters wait in the input register; kept ones then go to the output register
// throughput: one character per cycle unless the output stalls; mode and window step with it
// each character yields zero or one output transaction
// reset (rst_ni low, asynchronous): copy mode, window filled with 'a', both stages empty
`default_nettype none

module markup_span_stripper_unit import mss_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [CharW-1:0] in_char_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [CharW-1:0] out_char_o
);

  logic             in_valid_q;
  logic [CharW-1:0] in_char_q;
  logic             out_valid_q;
  logic [CharW-1:0] out_char_q;
  logic             advance;
  logic             emit;
  mss_step_t        step;

  // input stage moves on when the result slot is empty or being taken
  assign advance    = in_valid_q & (~out_valid_q | out_ready_i);
  assign in_ready_o = ~in_valid_q | advance;

  assign step.valid = advance;
  assign step.chr   = in_char_q;

  mss_filter u_filter (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .emit_o (emit)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= emit;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_char_q <= in_char_i;
    end
    if (emit) begin
      out_char_q <= in_char_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;

`ifndef SYNTHESIS
  a_emit_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> in_valid_q && (!out_valid_q || out_ready_i))
    else $error("result produced with no free slot");

  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(in_char_q))
    else $error("pending character lost");

  a_emit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> out_valid_o && out_char_o == $past(in_char_q))
    else $error("emitted character not presented");
`endif

endmodule

`default_nettype wire
